/* hw/rtl/clebuf_pkg.sv */
// Shared types, constants and operation codes for the cursor line-edit buffer.
// Depends on nothing; the front end, back end, top level and testbench import it.
`timescale 1ns / 1ps
`default_nettype none
package clebuf_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int OP_W         = 3;
  localparam int CHAR_W       = 8;
  localparam int POS_W        = 7;

  // Depth of the command queue between front and back (a power of two).
  localparam int QDEPTH = 2;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_LEFT      = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT     = 3'd2;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd3;
  localparam logic [OP_W-1:0] OP_READOUT   = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] symbol;
  } clebuf_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/clebuf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module clebuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hw/rtl/clebuf_front.sv */
// Front end: accepts input transfers, drops unused operation codes and queues
// the rest for the back end. Depends on clebuf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clebuf_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [clebuf_pkg::OP_W-1:0]   in_operation,
  input  wire logic [clebuf_pkg::CHAR_W-1:0] in_symbol,
  output clebuf_pkg::clebuf_cmd_t            cmd,
  input  wire logic                          cmd_pop
);
  import clebuf_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  logic [OP_W-1:0]   q_op_r  [QDEPTH];
  logic [CHAR_W-1:0] q_sym_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              enq;
  logic              deq;

  assign in_stall = (cnt_r == QCW'(QDEPTH));
  // Codes above readout are taken and discarded here.
  assign enq = in_valid && !in_stall && (in_operation <= OP_READOUT);
  assign deq = cmd_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_op_r[wr_ptr_r]  <= in_operation;
      q_sym_r[wr_ptr_r] <= in_symbol;
    end
  end

  always_comb begin
    cmd.valid  = (cnt_r != '0);
    cmd.op     = q_op_r[rd_ptr_r];
    cmd.symbol = q_sym_r[rd_ptr_r];
  end

endmodule
`default_nettype wire

/* hw/rtl/clebuf_back.sv */
// Back end: executes queued commands on the two character stacks and streams
// readout results. Depends on clebuf_pkg and clebuf_ram.
`timescale 1ns / 1ps
`default_nettype none
module clebuf_back #(
  parameter int CAPACITY = clebuf_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire clebuf_pkg::clebuf_cmd_t       cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [clebuf_pkg::CHAR_W-1:0]      out_text_char,
  output logic                               out_last,
  output logic                               out_empty_res,
  output logic                               out_overflowed,
  output logic [clebuf_pkg::POS_W-1:0]       out_cursor_pos
);
  import clebuf_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOVE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;
  logic [CW-1:0] acnt_r, acnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          dir_r, dir_nxt;      // 0: move left, 1: move right
  logic [CW-1:0] n_r, n_nxt;          // characters issued so far in a readout
  logic          pend_r, pend_nxt;    // a read word waits in a RAM output
  logic          psrc_r, psrc_nxt;    // 0: before stack, 1: after stack
  logic          plast_r, plast_nxt;

  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] oc_r, oc_nxt;
  logic              ol_r, ol_nxt;
  logic              oe_r, oe_nxt;
  logic              oo_r, oo_nxt;
  logic [POS_W-1:0]  op_r, op_nxt;

  logic              b_we, b_re, a_we, a_re;
  logic [AW-1:0]     b_waddr, b_raddr, a_waddr, a_raddr;
  logic [CHAR_W-1:0] b_wdata, a_wdata, b_rdata, a_rdata;

  logic [CW:0]   tot_c;
  logic [CW-1:0] tot_w;
  logic          can_load;
  logic          load;
  logic          more;
  logic          issue;

  assign tot_c    = {1'b0, bcnt_r} + {1'b0, acnt_r};
  assign tot_w    = CW'(tot_c);
  assign can_load = !ov_r || !out_stall;

  clebuf_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_before (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  clebuf_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_after (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    bcnt_nxt  = bcnt_r;
    acnt_nxt  = acnt_r;
    ovf_nxt   = ovf_r;
    dir_nxt   = dir_r;
    n_nxt     = n_r;
    pend_nxt  = pend_r;
    psrc_nxt  = psrc_r;
    plast_nxt = plast_r;
    cmd_pop   = 1'b0;
    b_we = 1'b0; b_re = 1'b0; a_we = 1'b0; a_re = 1'b0;
    b_waddr = AW'(bcnt_r);
    b_wdata = cmd.symbol;
    b_raddr = AW'(bcnt_r - 1'b1);
    a_waddr = AW'(acnt_r);
    a_wdata = b_rdata;
    a_raddr = AW'(acnt_r - 1'b1);
    load  = 1'b0;
    more  = (n_r != tot_w);
    issue = 1'b0;

    ov_nxt = ov_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    oe_nxt = oe_r;
    oo_nxt = oo_r;
    op_nxt = op_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd.valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_INSERT: begin
              if (tot_c >= (CW+1)'(CAPACITY)) begin
                ovf_nxt = 1'b1;
              end else begin
                b_we     = 1'b1;
                bcnt_nxt = bcnt_r + 1'b1;
              end
            end
            OP_LEFT: begin
              if (bcnt_r != '0 && acnt_r < CW'(CAPACITY)) begin
                b_re      = 1'b1;
                dir_nxt   = 1'b0;
                state_nxt = S_MOVE;
              end
            end
            OP_RIGHT: begin
              if (acnt_r != '0 && bcnt_r < CW'(CAPACITY)) begin
                a_re      = 1'b1;
                dir_nxt   = 1'b1;
                state_nxt = S_MOVE;
              end
            end
            OP_BACKSPACE: begin
              if (bcnt_r != '0) begin
                bcnt_nxt = bcnt_r - 1'b1;
              end
            end
            OP_READOUT: begin
              n_nxt    = '0;
              pend_nxt = 1'b0;
              if (tot_c == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOVE: begin
        // The word read last cycle crosses the cursor to the other stack.
        if (!dir_r) begin
          a_we     = 1'b1;
          a_wdata  = b_rdata;
          bcnt_nxt = bcnt_r - 1'b1;
          acnt_nxt = acnt_r + 1'b1;
        end else begin
          b_we     = 1'b1;
          b_wdata  = a_rdata;
          acnt_nxt = acnt_r - 1'b1;
          bcnt_nxt = bcnt_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_READ: begin
        load  = pend_r && can_load;
        issue = more && (!pend_r || can_load);
        if (load) begin
          ov_nxt   = 1'b1;
          oc_nxt   = psrc_r ? a_rdata : b_rdata;
          ol_nxt   = plast_r;
          oe_nxt   = 1'b0;
          oo_nxt   = ovf_r;
          op_nxt   = POS_W'(bcnt_r);
          pend_nxt = 1'b0;
        end
        if (issue) begin
          // Before stack bottom-up, then after stack top-down.
          if (n_r < bcnt_r) begin
            b_re     = 1'b1;
            b_raddr  = AW'(n_r);
            psrc_nxt = 1'b0;
          end else begin
            a_re     = 1'b1;
            a_raddr  = AW'(tot_w - 1'b1 - n_r);
            psrc_nxt = 1'b1;
          end
          plast_nxt = ((n_r + 1'b1) == tot_w);
          n_nxt     = n_r + 1'b1;
          pend_nxt  = 1'b1;
        end
        if (!more && (!pend_r || load)) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (can_load) begin
          ov_nxt    = 1'b1;
          oc_nxt    = '0;
          ol_nxt    = 1'b1;
          oe_nxt    = 1'b1;
          oo_nxt    = ovf_r;
          op_nxt    = POS_W'(bcnt_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bcnt_r  <= '0;
      acnt_r  <= '0;
      ovf_r   <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      n_r     <= '0;
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
      acnt_r  <= acnt_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      n_r     <= n_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    psrc_r  <= psrc_nxt;
    plast_r <= plast_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
    oe_r    <= oe_nxt;
    oo_r    <= oo_nxt;
    op_r    <= op_nxt;
  end

  assign out_valid      = ov_r;
  assign out_text_char  = oc_r;
  assign out_last       = ol_r;
  assign out_empty_res  = oe_r;
  assign out_overflowed = oo_r;
  assign out_cursor_pos = op_r;

endmodule
`default_nettype wire

/* hw/rtl/cursor_line_edit_buffer_top.sv */
// Top level of the cursor line-edit buffer (gap buffer with a cursor).
// Depends on clebuf_pkg, clebuf_front, clebuf_back and clebuf_ram.
//
// The input channel (in_valid, in_stall, in_operation, in_symbol) carries one
// edit operation per transfer: insert, cursor left, cursor right, backspace
// or readout. Unused operation codes are taken and discarded. Edits give no
// result; a readout gives one result transfer per character on the output
// channel (out_valid, out_stall and the out_ fields), the final one marked by
// out_last, or a single result with out_empty_res set when no text is held.
// A two-deep command queue parts the front from the back, so input transfers
// keep flowing while results wait on a stalled receiver; in_stall rises only
// when that queue is full.
// Insert and backspace are done in the idle state; a cursor move is a stack
// read, then a write to the other stack (through one port each). A readout
// issues one RAM read per character; each word waits in the RAM output and
// is then loaded into the output register, while the next read may issue.
// A stalled receiver holds the output register and the pending RAM word, and
// the readout resumes where it stopped. Reset (rst_n low, synchronous)
// empties the text, clears the sticky overflow flag and the queue; the
// character stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module cursor_line_edit_buffer_top #(
  parameter int CAPACITY = clebuf_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [clebuf_pkg::OP_W-1:0]   in_operation,
  input  wire logic [clebuf_pkg::CHAR_W-1:0] in_symbol,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [clebuf_pkg::CHAR_W-1:0]      out_text_char,
  output logic                               out_last,
  output logic                               out_empty_res,
  output logic                               out_overflowed,
  output logic [clebuf_pkg::POS_W-1:0]       out_cursor_pos
);
  import clebuf_pkg::*;

  // Command at the head of the queue, and the back end's pop of it.
  clebuf_cmd_t cmd;
  logic        cmd_pop;

  clebuf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_symbol    (in_symbol),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // The back end holds both stacks, their counts and the output register.
  clebuf_back #(.CAPACITY(CAPACITY)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_text_char  (out_text_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .out_overflowed (out_overflowed),
    .out_cursor_pos (out_cursor_pos)
  );

endmodule
`default_nettype wire

/* tb/cursor_line_edit_buffer_top_test.sv */
// Self-checking testbench for the cursor line-edit buffer top level.
// Depends on clebuf_pkg and cursor_line_edit_buffer_top; a gap-buffer model in
// the bench predicts every readout character and checks it against the block.
`timescale 1ns / 1ps
module cursor_line_edit_buffer_top_test;
  import clebuf_pkg::*;

  // Spare operation codes. The block must take them and do nothing.
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int TEXT_CAP     = CAPACITY_DEF;
  localparam int RANDOM_EDITS = 340;
  // The receiver holds off this long once, so that the command queue fills.
  localparam int LONG_HOLD    = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT   = 2000;
  // Cycles left to run after the last expected character has arrived.
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] symbol;
  } edit_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
    logic              empty_res;
    logic              overflowed;
    logic [POS_W-1:0]  cursor_pos;
  } text_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = OP_INSERT;
  logic [CHAR_W-1:0]   in_symbol = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHAR_W-1:0]   out_text_char;
  logic                out_last;
  logic                out_empty_res;
  logic                out_overflowed;
  logic [POS_W-1:0]    out_cursor_pos;

  cursor_line_edit_buffer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_text_char  (out_text_char),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res),
    .out_overflowed (out_overflowed),
    .out_cursor_pos (out_cursor_pos)
  );

  // The 12 ns clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Bench copy of the gap buffer. The left stack holds the text before the
  // cursor, oldest first; the right stack holds the text after it, with the
  // character next to the cursor on top.
  logic [CHAR_W-1:0] left_stack [TEXT_CAP];
  logic [CHAR_W-1:0] right_stack [TEXT_CAP];
  int                left_len = 0;
  int                right_len = 0;
  logic              dropped_flag = 1'b0;

  edit_cmd_t  pending_edits [$];
  text_beat_t expected_text [$];

  int   edits_taken = 0;
  int   error_count = 0;
  logic hold_on = 1'b0;

  // Applies one accepted edit to the bench buffer. A readout queues the whole
  // text, one character per result, exactly as the block must send it.
  task automatic apply_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] sym);
    int total;
    int sent;
    total = left_len + right_len;
    sent = 0;
    case (op)
      OP_INSERT: begin
        // A full buffer drops the character and latches the overflow flag.
        if (total >= TEXT_CAP) begin
          dropped_flag = 1'b1;
        end else begin
          left_stack[left_len] = sym;
          left_len++;
        end
      end
      OP_LEFT: begin
        if (left_len > 0) begin
          left_len--;
          right_stack[right_len] = left_stack[left_len];
          right_len++;
        end
      end
      OP_RIGHT: begin
        if (right_len > 0) begin
          right_len--;
          left_stack[left_len] = right_stack[right_len];
          left_len++;
        end
      end
      OP_BACKSPACE: begin
        if (left_len > 0) left_len--;
      end
      OP_READOUT: begin
        if (total == 0) begin
          // An empty buffer still answers, with a single marked result.
          expected_text.push_back('{'0, 1'b1, 1'b1, dropped_flag, POS_W'(left_len)});
        end else begin
          for (int i = 0; i < left_len; i++) begin
            expected_text.push_back('{left_stack[i], (sent + 1 == total), 1'b0,
                                      dropped_flag, POS_W'(left_len)});
            sent++;
          end
          for (int i = right_len; i > 0; i--) begin
            expected_text.push_back('{right_stack[i-1], (sent + 1 == total), 1'b0,
                                      dropped_flag, POS_W'(left_len)});
            sent++;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Input driver. It presents the oldest pending edit, holds it unchanged
  // while the block stalls, and after each edit idles for a random number of
  // cycles. Now and then it switches into a calm stretch with no idling.
  // The prediction is made at the edge where the transfer happens, so the
  // expectations are always queued well before the first character returns.
  int        send_gap = 0;
  logic      send_calm = 1'b0;
  edit_cmd_t next_edit;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= OP_INSERT;
      in_symbol <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_edit(in_operation, in_symbol);
        edits_taken++;
      end
      // A stalled edit stays on the port; otherwise the port is free.
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_edits.size() != 0) begin
          next_edit = pending_edits.pop_front();
          in_valid <= 1'b1;
          in_operation <= next_edit.op;
          in_symbol <= next_edit.symbol;
          if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver. Every result transfer is compared, field by
  // field, with the oldest expected character. After each transfer the
  // receiver stalls for a random number of cycles, and it also stalls now and
  // then while nothing is offered, so that a readout can meet a stall on its
  // very first character. The long hold from the pressure process is added.
  int         recv_wait = 0;
  logic       recv_calm = 1'b0;
  text_beat_t seen_beat;
  text_beat_t want_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_beat = '{out_text_char, out_last, out_empty_res, out_overflowed, out_cursor_pos};
        if (expected_text.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: char=%02h last=%0b empty=%0b ovf=%0b pos=%0d",
                     seen_beat.text_char, seen_beat.last, seen_beat.empty_res,
                     seen_beat.overflowed, seen_beat.cursor_pos);
        end else begin
          want_beat = expected_text.pop_front();
          if (seen_beat.text_char !== want_beat.text_char ||
              seen_beat.last !== want_beat.last ||
              seen_beat.empty_res !== want_beat.empty_res ||
              seen_beat.overflowed !== want_beat.overflowed ||
              seen_beat.cursor_pos !== want_beat.cursor_pos) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected char=%02h last=%0b empty=%0b ovf=%0b pos=%0d,",
                       want_beat.text_char, want_beat.last, want_beat.empty_res,
                       want_beat.overflowed, want_beat.cursor_pos);
              $display("  got char=%02h last=%0b empty=%0b ovf=%0b pos=%0d",
                       seen_beat.text_char, seen_beat.last, seen_beat.empty_res,
                       seen_beat.overflowed, seen_beat.cursor_pos);
            end
          end
        end
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
      end else if (!out_valid && recv_wait == 0 && !recv_calm && $urandom_range(0, 7) == 0) begin
        recv_wait = $urandom_range(1, 3);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_on;
      end
    end
  end

  // Back pressure: once the run is well under way the receiver refuses
  // results for a long stretch. The sender keeps offering edits, so a readout
  // blocks the back end, the command queue fills and in_stall must rise.
  initial begin
    while (edits_taken < 200) @(posedge clk);
    hold_on <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Hang detection: too many cycles in a row with no transfer on either side.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    edit_cmd_t cmd;
    int        made;
    int        mode;
    int        roll;

    // Directed edits: the corners of the cursor and the text, the extreme
    // symbol values, the spare codes and a readout of an empty buffer.
    pending_edits.push_back('{OP_READOUT, 8'h00});
    pending_edits.push_back('{OP_LEFT, 8'hFF});
    pending_edits.push_back('{OP_BACKSPACE, 8'hFF});
    pending_edits.push_back('{OP_RIGHT, 8'h00});
    pending_edits.push_back('{OP_READOUT, 8'hFF});
    pending_edits.push_back('{OP_INSERT, 8'h00});
    pending_edits.push_back('{OP_INSERT, 8'hFF});
    pending_edits.push_back('{OP_INSERT, "P"});
    pending_edits.push_back('{OP_INSERT, "L"});
    pending_edits.push_back('{OP_INSERT, "D"});
    pending_edits.push_back('{OP_INSERT, "B"});
    pending_edits.push_back('{OP_RIGHT, 8'h55});
    pending_edits.push_back('{OP_READOUT, 8'hAA});
    pending_edits.push_back('{OP_LEFT, 8'h00});
    pending_edits.push_back('{OP_LEFT, 8'h00});
    pending_edits.push_back('{OP_READOUT, 8'h00});
    pending_edits.push_back('{OP_SPARE_5, 8'hFF});
    pending_edits.push_back('{OP_SPARE_6, 8'h00});
    pending_edits.push_back('{OP_SPARE_7, 8'hA5});
    pending_edits.push_back('{OP_RIGHT, 8'h00});
    pending_edits.push_back('{OP_BACKSPACE, 8'h00});
    pending_edits.push_back('{OP_INSERT, 8'h5A});
    pending_edits.push_back('{OP_READOUT, 8'h00});

    // Fill the buffer to capacity and beyond, so that the overflow flag sets
    // and a readout carries the full 64 characters, one of them after the cursor.
    for (int i = 0; i < TEXT_CAP + 2; i++)
      pending_edits.push_back('{OP_INSERT, CHAR_W'($urandom_range(0, 255))});
    pending_edits.push_back('{OP_READOUT, 8'h00});
    for (int i = 0; i < 10; i++)
      pending_edits.push_back('{OP_LEFT, 8'h00});
    pending_edits.push_back('{OP_READOUT, 8'h00});

    // Random edits in phases: growing, shrinking or wandering text. Spare
    // codes are mixed in as noise and do not count toward the total.
    made = 0;
    mode = 0;
    while (made < RANDOM_EDITS) begin
      if (made % 40 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      cmd.symbol = CHAR_W'($urandom_range(0, 255));
      case (mode)
        0: cmd.op = (roll < 55) ? OP_INSERT : (roll < 65) ? OP_LEFT :
                    (roll < 75) ? OP_RIGHT : (roll < 83) ? OP_BACKSPACE :
                    (roll < 97) ? OP_READOUT : OP_SPARE_5;
        1: cmd.op = (roll < 15) ? OP_INSERT : (roll < 30) ? OP_LEFT :
                    (roll < 45) ? OP_RIGHT : (roll < 85) ? OP_BACKSPACE :
                    (roll < 97) ? OP_READOUT : OP_SPARE_6;
        default: cmd.op = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_LEFT :
                          (roll < 80) ? OP_RIGHT : (roll < 88) ? OP_BACKSPACE :
                          (roll < 98) ? OP_READOUT : OP_SPARE_7;
      endcase
      pending_edits.push_back(cmd);
      if (cmd.op <= OP_READOUT) made++;
    end

    // Single reset at the start of the run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every edit has been taken and every character has come back,
    // then give the block a few more cycles to show any stray result.
    while (pending_edits.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
